// File: sv/session_table_seq_ack_receiver_defines.svh
// Assertion macros for the receiver RTL.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef SESSION_TABLE_SEQ_ACK_RECEIVER_DEFINES_SVH
`define SESSION_TABLE_SEQ_ACK_RECEIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define STSAR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STSAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define STSAR_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define STSAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: sv/stsar_pkg.sv
package stsar_pkg;

  localparam int NUM_SESSIONS_DEF = 16;

  localparam int IP_W   = 32;
  localparam int PORT_W = 16;
  localparam int SEQ_W  = 16;
  localparam int LEN_W  = 11;
  localparam int SLOT_W = 4;
  localparam int KIND_W = 2;

  // Event codes reported with every acknowledgement
  localparam logic [KIND_W-1:0] EV_SYN      = 2'd0;
  localparam logic [KIND_W-1:0] EV_FIN      = 2'd1;
  localparam logic [KIND_W-1:0] EV_IN_ORDER = 2'd2;
  localparam logic [KIND_W-1:0] EV_OUT_ORD  = 2'd3;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic              look;
    logic              commit;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [SEQ_W-1:0]  exp;
    logic              keep;
  } cell_cmd_t;

  // Handed from each cell to the next one up the row
  typedef struct packed {
    logic hit;
    logic free;
  } cell_chain_t;

endpackage

// File: sv/session_table_seq_ack_receiver.sv
// Session table with cumulative acknowledgement.
// Request channel: present src_ip, src_port, syn_flag, fin_flag, seg_seq and
// payload_len with start high; the request is taken at the rising edge where
// start is high and busy is low. busy is high in the look and commit cycles
// that follow the accepting edge, so no new request is taken until both are over.
// Look: every cell compares the source against its own session at
// once; the hit and free marks ripple up the row of cells, so the matching
// slot, or else the lowest free one, claims the request.
// Commit: the claimed slot is read out, the acknowledgement is worked
// out and the slot's expected sequence and valid mark are written back.
// Result channel: ack_valid is high for exactly one cycle, the cycle after
// the commit, with ack_ip, ack_port, ack_number, slot_index and event_kind.
// The receiver cannot stall; results are never held back.
// A request from an unknown source with the table full gives no result.
// Reset (rst, synchronous) clears every valid mark and the controller at
// once; the block can take a request as soon as reset is released.
`include "session_table_seq_ack_receiver_defines.svh"

module session_table_seq_ack_receiver
  import stsar_pkg::*;
#(
  parameter int NUM_SESSIONS = NUM_SESSIONS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [IP_W-1:0]   src_ip,
  input  logic [PORT_W-1:0] src_port,
  input  logic              syn_flag,
  input  logic              fin_flag,
  input  logic [SEQ_W-1:0]  seg_seq,
  input  logic [LEN_W-1:0]  payload_len,
  output logic              ack_valid,
  output logic [IP_W-1:0]   ack_ip,
  output logic [PORT_W-1:0] ack_port,
  output logic [SEQ_W-1:0]  ack_number,
  output logic [SLOT_W-1:0] slot_index,
  output logic [KIND_W-1:0] event_kind
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOK   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // held request
  logic [IP_W-1:0]   req_ip;
  logic [PORT_W-1:0] req_port;
  logic              req_syn;
  logic              req_fin;
  logic [SEQ_W-1:0]  req_seq;
  logic [LEN_W-1:0]  req_len;
  logic              found;

  logic              accept;
  cell_cmd_t         cmd;
  cell_chain_t       chain [NUM_SESSIONS+1];
  logic [SEQ_W-1:0]  cell_exp [NUM_SESSIONS];
  logic [NUM_SESSIONS-1:0] sel_vec;
  logic              any_hit;

  logic [SEQ_W-1:0]  cur_exp;
  logic [SLOT_W-1:0] cur_slot;
  logic [SEQ_W-1:0]  seq_inc;
  logic [SEQ_W-1:0]  new_exp;
  logic [SEQ_W-1:0]  ack_calc;
  logic [KIND_W-1:0] kind_calc;
  logic              keep_calc;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_LOOK;
      S_LOOK:   state_next = S_COMMIT;
      S_COMMIT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      found     <= 1'b0;
      ack_valid <= 1'b0;
    end else begin
      state     <= state_next;
      if (state == S_LOOK) begin
        found <= chain[NUM_SESSIONS].hit | chain[NUM_SESSIONS].free;
      end
      ack_valid <= (state == S_COMMIT) && found;
    end
  end

  // capture the request; payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      req_ip   <= src_ip;
      req_port <= src_port;
      req_syn  <= syn_flag;
      req_fin  <= fin_flag;
      req_seq  <= seg_seq;
      req_len  <= payload_len;
    end
  end

  // Row of session cells; hit and free marks ripple from slot 0 upward
  assign chain[0] = '0;
  assign any_hit  = chain[NUM_SESSIONS].hit;

  assign cmd.look   = (state == S_LOOK);
  assign cmd.commit = (state == S_COMMIT);
  assign cmd.ip     = req_ip;
  assign cmd.port   = req_port;
  assign cmd.exp    = new_exp;
  assign cmd.keep   = keep_calc;

  for (genvar i = 0; i < NUM_SESSIONS; i++) begin : g_cell
    stsar_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .any_hit   (any_hit),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .sel       (sel_vec[i]),
      .exp_out   (cell_exp[i])
    );
  end

  // Read out the claimed slot: at most one cell is selected
  always_comb begin
    cur_exp  = '0;
    cur_slot = '0;
    for (int i = 0; i < NUM_SESSIONS; i++) begin
      cur_exp = cur_exp | cell_exp[i];
      if (sel_vec[i]) begin
        cur_slot = cur_slot | SLOT_W'(i);
      end
    end
  end

  // Work out the acknowledgement; SYN takes precedence over FIN
  assign seq_inc = req_seq + SEQ_W'(1);

  always_comb begin
    priority if (req_syn) begin
      new_exp   = seq_inc;
      ack_calc  = seq_inc;
      kind_calc = EV_SYN;
      keep_calc = 1'b1;
    end else if (req_fin) begin
      new_exp   = cur_exp;
      ack_calc  = seq_inc;
      kind_calc = EV_FIN;
      keep_calc = 1'b0;
    end else if (req_seq == cur_exp) begin
      new_exp   = cur_exp + SEQ_W'(req_len);
      ack_calc  = cur_exp + SEQ_W'(req_len);
      kind_calc = EV_IN_ORDER;
      keep_calc = 1'b1;
    end else begin
      new_exp   = cur_exp;
      ack_calc  = cur_exp;
      kind_calc = EV_OUT_ORD;
      keep_calc = 1'b1;
    end
  end

  // Result register; valid for one cycle only
  always_ff @(posedge clk) begin
    if (state == S_COMMIT) begin
      ack_ip     <= req_ip;
      ack_port   <= req_port;
      ack_number <= ack_calc;
      slot_index <= cur_slot;
      event_kind <= kind_calc;
    end
  end

  `STSAR_ASSERT_NOW(a_state_onehot, clk, rst, 1'b1, $onehot(state),
                    "controller state is not one-hot")
  `STSAR_ASSERT_NOW(a_sel_unique, clk, rst, state == S_COMMIT, $onehot0(sel_vec),
                    "more than one slot claimed the request")
  `STSAR_ASSERT_NOW(a_found_sel, clk, rst, state == S_COMMIT,
                    found == (sel_vec != '0),
                    "claim mark disagrees with selected cells")
  `STSAR_ASSERT_NEXT(a_accept_look, clk, rst, accept, state == S_LOOK,
                     "accepted request did not enter look")
  `STSAR_ASSERT_NOW(a_result_after_commit, clk, rst, ack_valid,
                    $past(state == S_COMMIT) && !busy,
                    "result strobe without a preceding commit")

endmodule

// File: sv/stsar_cell.sv
module stsar_cell
  import stsar_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_cmd_t        cmd,
  input  logic             any_hit,
  input  cell_chain_t      chain_in,
  output cell_chain_t      chain_out,
  output logic             sel,
  output logic [SEQ_W-1:0] exp_out
);

  logic              valid;
  logic [IP_W-1:0]   ip;
  logic [PORT_W-1:0] port;
  logic [SEQ_W-1:0]  exp;
  logic              hit;
  logic              alloc;

  assign hit   = valid && (ip == cmd.ip) && (port == cmd.port);
  // take this slot only if nothing matched and no lower slot is free
  assign alloc = !valid && !chain_in.free && !any_hit;

  assign chain_out.hit  = chain_in.hit | hit;
  assign chain_out.free = chain_in.free | !valid;

  // a freshly allocated slot starts at expected sequence zero
  assign exp_out = (sel && valid) ? exp : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sel   <= 1'b0;
    end else begin
      if (cmd.look) begin
        sel <= hit | alloc;
      end
      if (cmd.commit && sel) begin
        valid <= cmd.keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && sel) begin
      ip   <= cmd.ip;
      port <= cmd.port;
      exp  <= cmd.exp;
    end
  end

endmodule
